### src/vcard_content_line_tokenizer_top_assert.svh
// Assertion macros used by the checker file.
`ifndef VCARD_CONTENT_LINE_TOKENIZER_TOP_ASSERT_SVH
`define VCARD_CONTENT_LINE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define VCLT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define VCLT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### src/vclt_pkg.sv
`default_nettype none
package vclt_pkg;

	localparam int TRAIL_DEPTH_DEF = 16;
	localparam int HEAD_DEPTH = 11;
	localparam int MAX_RESULTS = 30;
	localparam int IN_Q_DEPTH = 2;
	localparam int OUT_Q_DEPTH = 4;

	localparam logic [2:0] KIND_NAME = 3'd0;
	localparam logic [2:0] KIND_PARAM = 3'd1;
	localparam logic [2:0] KIND_VALUE = 3'd2;
	localparam logic [2:0] KIND_BOUND = 3'd3;
	localparam logic [2:0] KIND_PEND = 3'd4;
	localparam logic [2:0] KIND_CBEGIN = 3'd5;
	localparam logic [2:0] KIND_CEND = 3'd6;
	localparam logic [2:0] KIND_ERROR = 3'd7;

	localparam logic [1:0] ERR_ORPHAN = 2'd0;
	localparam logic [1:0] ERR_NESTED = 2'd1;
	localparam logic [1:0] ERR_EOF = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	localparam logic [1:0] TC_CR = 2'd0;
	localparam logic [1:0] TC_VT = 2'd1;
	localparam logic [1:0] TC_FF = 2'd2;
	localparam logic [1:0] TC_NUL = 2'd3;

	localparam logic [1:0] FP_NAME = 2'd0;
	localparam logic [1:0] FP_PARAM = 2'd1;
	localparam logic [1:0] FP_VALUE = 2'd2;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic [8*11-1:0] KW_BEGIN = "BEGIN:VCARD";
	localparam logic [8*9-1:0] KW_END = "END:VCARD";

	typedef enum logic [1:0] {PH_START, PH_HEAD, PH_BODY, PH_MUTE} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PRE, ST_HEAD, ST_TRAIL, ST_BYTE, ST_POST, ST_FIN
	} bst_t;

	typedef struct packed {
		logic kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] out_kind;
		logic [7:0] out_byte;
		logic [1:0] error_code;
		logic last_of_run;
	} res_item_t;

	typedef struct packed {
		logic eof;
		logic lf;
		logic tvalid;
		logic [1:0] tcode;
		logic ws;
		logic [7:0] data;
	} cls_item_t;

	typedef struct packed {
		logic emit;
		res_item_t rec;
		logic [1:0] fp;
	} content_t;

	function automatic logic [7:0] kw_begin_at(input logic [3:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (p < 4'd11) r = KW_BEGIN[8*(10-int'(p)) +: 8];
		return r;
	endfunction

	function automatic logic [7:0] kw_end_at(input logic [3:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (p < 4'd9) r = KW_END[8*(8-int'(p)) +: 8];
		return r;
	endfunction

	function automatic logic [7:0] trail_value(input logic [1:0] c);
		logic [7:0] r;
		case (c)
			TC_CR: r = CH_CR;
			TC_VT: r = CH_VT;
			TC_FF: r = CH_FF;
			default: r = CH_NUL;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
	endfunction

	// One byte of a property line: moves the field part and maybe emits.
	function automatic content_t content(input logic [1:0] fp, input logic [7:0] b,
			input logic en);
		content_t r;
		r = '0;
		r.fp = fp;
		if (fp != FP_VALUE && b == CH_COLON) begin
			r.fp = FP_VALUE;
		end else if (fp != FP_VALUE && b == CH_SEMI) begin
			r.fp = FP_PARAM;
			r.emit = en;
			r.rec.out_kind = KIND_BOUND;
		end else if (en) begin
			r.emit = 1'b1;
			r.rec.out_byte = b;
			case (fp)
				FP_NAME: r.rec.out_kind = KIND_NAME;
				FP_PARAM: begin
					r.rec.out_kind = KIND_PARAM;
					r.rec.out_byte = to_lower(b);
				end
				default: r.rec.out_kind = KIND_VALUE;
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/vclt_fifo.sv
`default_nettype none
module vclt_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire T wr_data,
	output logic full,
	input wire logic rd_en,
	output T rd_data,
	output logic empty
);
	localparam int AW = $clog2(DEPTH);

	T mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + AW'(1);
			if (do_rd) rptr_q <= rptr_q + AW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + (AW+1)'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end
endmodule
`default_nettype wire

### src/vclt_front.sv
`default_nettype none
module vclt_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire vclt_pkg::in_item_t item,
	output logic full,
	output logic out_valid,
	output vclt_pkg::cls_item_t out_item,
	input wire logic out_pop
);
	vclt_pkg::cls_item_t cls;
	logic q_empty;

	always_comb begin
		cls.eof = item.kind;
		cls.data = item.data_byte;
		cls.lf = (item.data_byte == vclt_pkg::CH_LF);
		cls.ws = (item.data_byte == vclt_pkg::CH_SPACE) || (item.data_byte == vclt_pkg::CH_TAB)
			|| (item.data_byte == vclt_pkg::CH_NUL);
		cls.tvalid = 1'b1;
		case (item.data_byte)
			vclt_pkg::CH_CR: cls.tcode = vclt_pkg::TC_CR;
			vclt_pkg::CH_VT: cls.tcode = vclt_pkg::TC_VT;
			vclt_pkg::CH_FF: cls.tcode = vclt_pkg::TC_FF;
			vclt_pkg::CH_NUL: cls.tcode = vclt_pkg::TC_NUL;
			default: begin
				cls.tcode = vclt_pkg::TC_CR;
				cls.tvalid = 1'b0;
			end
		endcase
	end

	vclt_fifo #(.T(vclt_pkg::cls_item_t), .DEPTH(vclt_pkg::IN_Q_DEPTH)) u_q (
		.clk(clk), .arst_n(arst_n),
		.wr_en(push), .wr_data(cls), .full(full),
		.rd_en(out_pop), .rd_data(out_item), .empty(q_empty)
	);

	assign out_valid = !q_empty;
endmodule
`default_nettype wire

### src/vclt_back.sv
`default_nettype none
module vclt_back #(
	parameter int TRAIL_DEPTH = vclt_pkg::TRAIL_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire vclt_pkg::cls_item_t in_item,
	output logic in_pop,
	output logic res_push,
	output vclt_pkg::res_item_t res_item,
	input wire logic res_full
);
	localparam int TCW = $clog2(TRAIL_DEPTH + 1);
	localparam int TIW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;

	vclt_pkg::bst_t state_q, state_d;
	vclt_pkg::phase_t phase_q, phase_d;
	logic inside_q, inside_d, popen_q, popen_d, halted_q, halted_d;
	logic [1:0] fp_q, fp_d, km_q, km_d;
	logic [3:0] hc_q, hc_d;
	logic [TCW-1:0] tc_q, tc_d;
	logic [7:0] hb_q [vclt_pkg::HEAD_DEPTH];
	logic [1:0] tb_q [TRAIL_DEPTH];

	// Work list of the item in progress.
	logic ev_prop_q, ev_mark_q, do_byte_q, ev_err2_q, fp_clr_q, cin_q;
	logic pl_prop, pl_mark, pl_byte, pl_err2, pl_fpclr;
	logic [2:0] mk_kind_q, pl_mkind;
	logic [1:0] mk_err_q, pl_merr;
	logic [3:0] fh_n_q, pl_fh, hidx_q;
	logic [TCW-1:0] ft_n_q, pl_ft, tidx_q;
	logic [7:0] byte_q, cbyte;

	vclt_pkg::res_item_t hold_q, emit_rec;
	logic hold_v_q, emit_v, emit_ok, take, adv, any_work;
	logic [4:0] ecnt_q;
	vclt_pkg::content_t cres;

	logic hb_we, tb_we, le, hgo;
	logic [3:0] hpos;
	logic [1:0] hm;
	logic [7:0] up;

	assign take = (state_q == vclt_pkg::ST_IDLE) && in_valid;
	assign in_pop = take;
	assign adv = (state_q == vclt_pkg::ST_IDLE) || !res_full;

	function automatic vclt_pkg::bst_t pick(input logic h, input logic t, input logic b,
			input logic p);
		vclt_pkg::bst_t r;
		if (h) r = vclt_pkg::ST_HEAD;
		else if (t) r = vclt_pkg::ST_TRAIL;
		else if (b) r = vclt_pkg::ST_BYTE;
		else if (p) r = vclt_pkg::ST_POST;
		else r = vclt_pkg::ST_FIN;
		return r;
	endfunction

	// Decide what the new item does to the line state and what it will emit.
	always_comb begin
		inside_d = inside_q;
		popen_d = popen_q;
		halted_d = halted_q;
		phase_d = phase_q;
		fp_d = fp_q;
		hc_d = hc_q;
		km_d = km_q;
		tc_d = tc_q;
		hb_we = 1'b0;
		tb_we = 1'b0;
		le = 1'b0;
		hgo = 1'b0;
		hpos = hc_q;
		hm = km_q;
		up = vclt_pkg::to_upper(in_item.data);
		pl_prop = 1'b0;
		pl_mark = 1'b0;
		pl_mkind = vclt_pkg::KIND_ERROR;
		pl_merr = vclt_pkg::ERR_ORPHAN;
		pl_fh = '0;
		pl_ft = '0;
		pl_byte = 1'b0;
		pl_err2 = 1'b0;
		pl_fpclr = 1'b0;
		if (take && !halted_q) begin
			if (in_item.eof) begin
				le = (phase_q != vclt_pkg::PH_START) || (tc_q != '0);
			end else if (in_item.lf) begin
				le = 1'b1;
			end else if (phase_q == vclt_pkg::PH_MUTE) begin
				le = 1'b0;
			end else if (in_item.tvalid && !(phase_q == vclt_pkg::PH_START && tc_q == '0
					&& in_item.tcode == vclt_pkg::TC_NUL)) begin
				if (tc_q < TCW'(TRAIL_DEPTH)) begin
					tb_we = 1'b1;
					tc_d = tc_q + TCW'(1);
				end else begin
					pl_mark = 1'b1;
					pl_merr = vclt_pkg::ERR_OVERFLOW;
				end
			end else if (phase_q == vclt_pkg::PH_START) begin
				if (tc_q == '0 && in_item.ws) begin
					if (popen_q) begin
						phase_d = vclt_pkg::PH_BODY;
					end else begin
						pl_mark = 1'b1;
						phase_d = vclt_pkg::PH_MUTE;
					end
				end else begin
					pl_prop = inside_q && popen_q;
					popen_d = 1'b1;
					fp_d = vclt_pkg::FP_NAME;
					hgo = 1'b1;
					hpos = '0;
					hm = 2'b11;
				end
			end else if (phase_q == vclt_pkg::PH_HEAD) begin
				hgo = 1'b1;
			end else begin
				pl_ft = tc_q;
				tc_d = '0;
				pl_byte = 1'b1;
			end

			if (hgo) begin
				if (tc_q != '0) begin
					pl_fh = hpos;
					pl_ft = tc_q;
					tc_d = '0;
					pl_byte = 1'b1;
					hc_d = '0;
					km_d = hm;
					phase_d = vclt_pkg::PH_BODY;
				end else begin
					if (hpos >= 4'd11 || up != vclt_pkg::kw_begin_at(hpos)) hm[0] = 1'b0;
					if (hpos >= 4'd9 || up != vclt_pkg::kw_end_at(hpos)) hm[1] = 1'b0;
					km_d = hm;
					if (hm == 2'b00) begin
						pl_fh = hpos;
						hc_d = '0;
						pl_byte = 1'b1;
						phase_d = vclt_pkg::PH_BODY;
					end else begin
						hb_we = 1'b1;
						hc_d = hpos + 4'd1;
						phase_d = vclt_pkg::PH_HEAD;
					end
				end
			end

			if (le) begin
				if (phase_q == vclt_pkg::PH_START) begin
					pl_mark = !popen_q;
				end else if (phase_q == vclt_pkg::PH_HEAD) begin
					if (hc_q == 4'd11 && km_q[0]) begin
						pl_mark = 1'b1;
						if (inside_q) begin
							pl_merr = vclt_pkg::ERR_NESTED;
							halted_d = 1'b1;
						end else begin
							pl_mkind = vclt_pkg::KIND_CBEGIN;
							pl_merr = vclt_pkg::ERR_ORPHAN;
							inside_d = 1'b1;
							popen_d = 1'b0;
						end
					end else if (hc_q == 4'd9 && km_q[1] && inside_q) begin
						pl_mark = 1'b1;
						pl_mkind = vclt_pkg::KIND_CEND;
						inside_d = 1'b0;
						popen_d = 1'b0;
					end else begin
						pl_fh = hc_q;
					end
				end
				tc_d = '0;
				hc_d = '0;
				km_d = 2'b11;
				phase_d = vclt_pkg::PH_START;
			end

			if (in_item.eof) begin
				if (!halted_d && inside_d) begin
					pl_err2 = 1'b1;
					inside_d = 1'b0;
				end
				popen_d = 1'b0;
				if (pl_fh == '0) fp_d = vclt_pkg::FP_NAME;
				else pl_fpclr = 1'b1;
			end
		end
	end

	always_comb begin
		case (state_q)
			vclt_pkg::ST_HEAD: cbyte = hb_q[hidx_q];
			vclt_pkg::ST_TRAIL: cbyte = vclt_pkg::trail_value(tb_q[tidx_q[TIW-1:0]]);
			default: cbyte = byte_q;
		endcase
		cres = vclt_pkg::content(fp_q, cbyte, cin_q);
	end

	// Next state.
	always_comb begin
		any_work = pl_prop || pl_mark || (pl_fh != '0) || (pl_ft != '0) || pl_byte || pl_err2;
		state_d = state_q;
		case (state_q)
			vclt_pkg::ST_IDLE: begin
				if (take && any_work) begin
					if (pl_prop || pl_mark) state_d = vclt_pkg::ST_PRE;
					else state_d = pick(pl_fh != '0, pl_ft != '0, pl_byte, pl_err2);
				end
			end
			vclt_pkg::ST_PRE: begin
				if (adv && !(ev_prop_q && ev_mark_q))
					state_d = pick(fh_n_q != '0, ft_n_q != '0, do_byte_q, ev_err2_q);
			end
			vclt_pkg::ST_HEAD: begin
				if (adv && hidx_q == fh_n_q - 4'd1)
					state_d = pick(1'b0, ft_n_q != '0, do_byte_q, ev_err2_q);
			end
			vclt_pkg::ST_TRAIL: begin
				if (adv && tidx_q == ft_n_q - TCW'(1))
					state_d = pick(1'b0, 1'b0, do_byte_q, ev_err2_q);
			end
			vclt_pkg::ST_BYTE: begin
				if (adv) state_d = pick(1'b0, 1'b0, 1'b0, ev_err2_q);
			end
			vclt_pkg::ST_POST: begin
				if (adv && !ev_err2_q) state_d = vclt_pkg::ST_FIN;
			end
			vclt_pkg::ST_FIN: begin
				if (adv) state_d = vclt_pkg::ST_IDLE;
			end
			default: state_d = vclt_pkg::ST_IDLE;
		endcase
	end

	// Result of the current step.
	always_comb begin
		emit_v = 1'b0;
		emit_rec = '0;
		case (state_q)
			vclt_pkg::ST_PRE: begin
				emit_v = 1'b1;
				if (ev_prop_q) begin
					emit_rec.out_kind = vclt_pkg::KIND_PEND;
				end else begin
					emit_rec.out_kind = mk_kind_q;
					emit_rec.error_code = mk_err_q;
				end
			end
			vclt_pkg::ST_HEAD, vclt_pkg::ST_TRAIL, vclt_pkg::ST_BYTE: begin
				emit_v = cres.emit;
				emit_rec = cres.rec;
			end
			vclt_pkg::ST_POST: begin
				emit_v = 1'b1;
				if (ev_err2_q) begin
					emit_rec.out_kind = vclt_pkg::KIND_ERROR;
					emit_rec.error_code = vclt_pkg::ERR_EOF;
				end else begin
					emit_rec.out_kind = vclt_pkg::KIND_CEND;
				end
			end
			default: emit_v = 1'b0;
		endcase
	end

	assign emit_ok = emit_v && (ecnt_q < 5'(vclt_pkg::MAX_RESULTS));

	// The newest result waits in a hold register until we know if it is the last.
	assign res_push = adv && hold_v_q && ((state_q == vclt_pkg::ST_FIN) || emit_ok);
	always_comb begin
		res_item = hold_q;
		res_item.last_of_run = (state_q == vclt_pkg::ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vclt_pkg::ST_IDLE;
			phase_q <= vclt_pkg::PH_START;
			inside_q <= 1'b0;
			popen_q <= 1'b0;
			halted_q <= 1'b0;
			fp_q <= vclt_pkg::FP_NAME;
			hc_q <= '0;
			km_q <= 2'b11;
			tc_q <= '0;
			ev_prop_q <= 1'b0;
			ev_mark_q <= 1'b0;
			do_byte_q <= 1'b0;
			ev_err2_q <= 1'b0;
			fp_clr_q <= 1'b0;
			cin_q <= 1'b0;
			fh_n_q <= '0;
			ft_n_q <= '0;
			hidx_q <= '0;
			tidx_q <= '0;
			hold_v_q <= 1'b0;
			ecnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				phase_q <= phase_d;
				inside_q <= inside_d;
				popen_q <= popen_d;
				halted_q <= halted_d;
				fp_q <= fp_d;
				hc_q <= hc_d;
				km_q <= km_d;
				tc_q <= tc_d;
				ev_prop_q <= pl_prop;
				ev_mark_q <= pl_mark;
				do_byte_q <= pl_byte;
				ev_err2_q <= pl_err2;
				fp_clr_q <= pl_fpclr;
				cin_q <= inside_q;
				fh_n_q <= pl_fh;
				ft_n_q <= pl_ft;
				hidx_q <= '0;
				tidx_q <= '0;
				ecnt_q <= '0;
			end else if (adv && state_q != vclt_pkg::ST_IDLE) begin
				case (state_q)
					vclt_pkg::ST_PRE: begin
						if (ev_prop_q) ev_prop_q <= 1'b0;
						else ev_mark_q <= 1'b0;
					end
					vclt_pkg::ST_HEAD: begin
						fp_q <= cres.fp;
						hidx_q <= hidx_q + 4'd1;
					end
					vclt_pkg::ST_TRAIL: begin
						fp_q <= cres.fp;
						tidx_q <= tidx_q + TCW'(1);
					end
					vclt_pkg::ST_BYTE: fp_q <= cres.fp;
					vclt_pkg::ST_POST: begin
						if (ev_err2_q) ev_err2_q <= 1'b0;
					end
					vclt_pkg::ST_FIN: begin
						if (fp_clr_q) fp_q <= vclt_pkg::FP_NAME;
						fp_clr_q <= 1'b0;
						hold_v_q <= 1'b0;
					end
					default: hold_v_q <= hold_v_q;
				endcase
				if (emit_ok) begin
					hold_v_q <= 1'b1;
					ecnt_q <= ecnt_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= in_item.data;
			mk_kind_q <= pl_mkind;
			mk_err_q <= pl_merr;
		end
		if (hb_we) hb_q[hpos] <= in_item.data;
		if (tb_we) tb_q[tc_q[TIW-1:0]] <= in_item.tcode;
		if (adv && emit_ok && state_q != vclt_pkg::ST_IDLE) hold_q <= emit_rec;
	end
endmodule
`default_nettype wire

### src/vcard_content_line_tokenizer_top.sv
`default_nettype none
// vCard content-line tokenizer.
// Input queue: drive item {kind, data_byte} with push; a request is taken at a
// clock edge where push is high and full is low. kind 1 marks end of input.
// Result queue: while empty is low the oldest result sits on result; raise pop
// to take it. Each input request yields zero to thirty results, and the last
// result of a request carries last_of_run.
// Sequencing: the back end takes a request only while idle. A request that only updates
// line state (a held keyword byte or line-end byte) is done then; any other
// walks the sequencer steps in order (property end, marker, each held keyword
// byte, each held line-end byte, the byte itself, each end-of-input trailer)
// and then a closing step; each step waits while the result queue is full.
// A two-entry queue sits between the classifier and the sequencer and a
// four-entry queue holds results, so the input side keeps taking requests while
// the receiver stalls, until both queues fill and full rises.
// Reset (arst_n low) empties both queues and returns to outside any card, at a
// line start; a halt after a nested card begin also clears only on reset.
module vcard_content_line_tokenizer_top #(
	parameter int TRAIL_DEPTH = vclt_pkg::TRAIL_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire vclt_pkg::in_item_t item,
	output logic full,
	output logic empty,
	input wire logic pop,
	output vclt_pkg::res_item_t result
);
	logic cls_valid, cls_pop, res_push, res_full;
	vclt_pkg::cls_item_t cls_item;
	vclt_pkg::res_item_t res_item;

	vclt_front u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .item(item), .full(full),
		.out_valid(cls_valid), .out_item(cls_item), .out_pop(cls_pop)
	);

	vclt_back #(.TRAIL_DEPTH(TRAIL_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cls_valid), .in_item(cls_item), .in_pop(cls_pop),
		.res_push(res_push), .res_item(res_item), .res_full(res_full)
	);

	vclt_fifo #(.T(vclt_pkg::res_item_t), .DEPTH(vclt_pkg::OUT_Q_DEPTH)) u_outq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(res_push), .wr_data(res_item), .full(res_full),
		.rd_en(pop), .rd_data(result), .empty(empty)
	);
endmodule
`default_nettype wire

### src/vclt_checker.sv
`default_nettype none
`include "vcard_content_line_tokenizer_top_assert.svh"
module vclt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire vclt_pkg::in_item_t item,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire vclt_pkg::res_item_t result
);
	logic unused_in;
	assign unused_in = push ^ full ^ (^item);

	`VCLT_ASSERT_IMP(a_marker_byte_zero, !empty && result.out_kind > vclt_pkg::KIND_VALUE, result.out_byte == 8'h00, "marker result carries a byte")
	`VCLT_ASSERT_IMP(a_code_only_on_error, !empty && result.error_code != 2'd0, result.out_kind == vclt_pkg::KIND_ERROR, "error code on a non-error result")
	`VCLT_ASSERT_IMP(a_param_lower, !empty && result.out_kind == vclt_pkg::KIND_PARAM, !(result.out_byte >= 8'h41 && result.out_byte <= 8'h5A), "parameter byte not lower-cased")
	`VCLT_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(result), "waiting result changed")
endmodule

bind vcard_content_line_tokenizer_top vclt_checker u_chk (.*);
`default_nettype wire

### bench/tb_vcard_content_line_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

class card_scoreboard;
	vclt_pkg::res_item_t pending_tokens[$];
	int errors;
	int results_seen;
	int items_noted;

	// Tokenizer state mirrored for prediction.
	bit in_card;
	logic [1:0] part;
	bit prop_open;
	vclt_pkg::phase_t phase;
	logic [7:0] head_buf[11];
	int head_n;
	logic [1:0] kw_alive;
	logic [1:0] trail_buf[32];
	int trail_n;
	bit stopped;
	int trail_limit;
	vclt_pkg::res_item_t step_out[$];

	function new(int depth);
		trail_limit = depth;
		errors = 0;
		results_seen = 0;
		items_noted = 0;
		in_card = 0;
		part = vclt_pkg::FP_NAME;
		prop_open = 0;
		phase = vclt_pkg::PH_START;
		head_n = 0;
		kw_alive = 2'b11;
		trail_n = 0;
		stopped = 0;
	endfunction

	function void put(logic [2:0] k, logic [7:0] b, logic [1:0] e);
		vclt_pkg::res_item_t r;
		if (step_out.size() >= vclt_pkg::MAX_RESULTS) return;
		r.out_kind = k;
		r.out_byte = b;
		r.error_code = e;
		r.last_of_run = 1'b0;
		step_out.push_back(r);
	endfunction

	function void text_byte(logic [7:0] b);
		logic [1:0] p;
		p = part;
		if (p != vclt_pkg::FP_VALUE && b == vclt_pkg::CH_COLON) begin
			part = vclt_pkg::FP_VALUE;
			return;
		end
		if (p != vclt_pkg::FP_VALUE && b == vclt_pkg::CH_SEMI) begin
			part = vclt_pkg::FP_PARAM;
			if (in_card) put(vclt_pkg::KIND_BOUND, 8'h00, 2'd0);
			return;
		end
		if (!in_card) return;
		if (p == vclt_pkg::FP_NAME) put(vclt_pkg::KIND_NAME, b, 2'd0);
		else if (p == vclt_pkg::FP_PARAM)
			put(vclt_pkg::KIND_PARAM, (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b, 2'd0);
		else put(vclt_pkg::KIND_VALUE, b, 2'd0);
	endfunction

	function void release_trail();
		logic [7:0] v;
		for (int i = 0; i < trail_n; i++) begin
			case (trail_buf[i])
				vclt_pkg::TC_CR: v = vclt_pkg::CH_CR;
				vclt_pkg::TC_VT: v = vclt_pkg::CH_VT;
				vclt_pkg::TC_FF: v = vclt_pkg::CH_FF;
				default: v = vclt_pkg::CH_NUL;
			endcase
			text_byte(v);
		end
		trail_n = 0;
	endfunction

	function void release_head();
		for (int i = 0; i < head_n; i++) text_byte(head_buf[i]);
		head_n = 0;
	endfunction

	function logic [7:0] kw_char(bit is_begin, int pos);
		string s;
		s = is_begin ? "BEGIN:VCARD" : "END:VCARD";
		return s[pos];
	endfunction

	function void keyword_byte(logic [7:0] b);
		logic [1:0] m;
		logic [7:0] u;
		m = kw_alive;
		u = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
		if (trail_n > 0) begin
			release_head();
			release_trail();
			text_byte(b);
			phase = vclt_pkg::PH_BODY;
			return;
		end
		if (head_n >= 11 || u != kw_char(1, head_n)) m[0] = 1'b0;
		if (head_n >= 9 || u != kw_char(0, head_n)) m[1] = 1'b0;
		if (m == 2'b00) begin
			release_head();
			text_byte(b);
			phase = vclt_pkg::PH_BODY;
		end else begin
			head_buf[head_n] = b;
			head_n++;
			kw_alive = m;
		end
	endfunction

	function void finish_line();
		if (phase == vclt_pkg::PH_START) begin
			if (!prop_open) put(vclt_pkg::KIND_ERROR, 8'h00, vclt_pkg::ERR_ORPHAN);
		end else if (phase == vclt_pkg::PH_HEAD) begin
			if (head_n == 11 && kw_alive[0]) begin
				if (in_card) begin
					put(vclt_pkg::KIND_ERROR, 8'h00, vclt_pkg::ERR_NESTED);
					stopped = 1;
				end else begin
					in_card = 1;
					prop_open = 0;
					put(vclt_pkg::KIND_CBEGIN, 8'h00, 2'd0);
				end
			end else if (head_n == 9 && kw_alive[1] && in_card) begin
				put(vclt_pkg::KIND_CEND, 8'h00, 2'd0);
				in_card = 0;
				prop_open = 0;
			end else begin
				release_head();
			end
		end
		trail_n = 0;
		head_n = 0;
		kw_alive = 2'b11;
		phase = vclt_pkg::PH_START;
	endfunction

	function int line_end_code(logic [7:0] b);
		case (b)
			vclt_pkg::CH_CR: return 0;
			vclt_pkg::CH_VT: return 1;
			vclt_pkg::CH_FF: return 2;
			vclt_pkg::CH_NUL: return 3;
			default: return -1;
		endcase
	endfunction

	// Notes an accepted request and queues the tokens it should produce.
	function void note_request(vclt_pkg::in_item_t it);
		int code;
		logic [7:0] b;
		b = it.data_byte;
		items_noted++;
		step_out.delete();
		if (stopped) return;
		code = line_end_code(b);
		if (it.kind) begin
			if (phase != vclt_pkg::PH_START || trail_n > 0) finish_line();
			if (!stopped && in_card) begin
				put(vclt_pkg::KIND_ERROR, 8'h00, vclt_pkg::ERR_EOF);
				put(vclt_pkg::KIND_CEND, 8'h00, 2'd0);
				in_card = 0;
			end
			prop_open = 0;
			part = vclt_pkg::FP_NAME;
		end else if (b == vclt_pkg::CH_LF) begin
			finish_line();
		end else if (phase == vclt_pkg::PH_MUTE) begin
		end else if (code >= 0 &&
				!(phase == vclt_pkg::PH_START && trail_n == 0 && b == 8'h00)) begin
			if (trail_n < trail_limit && trail_n < 32) begin
				trail_buf[trail_n] = code[1:0];
				trail_n++;
			end else begin
				put(vclt_pkg::KIND_ERROR, 8'h00, vclt_pkg::ERR_OVERFLOW);
			end
		end else if (phase == vclt_pkg::PH_START) begin
			if (trail_n == 0 && (b == vclt_pkg::CH_SPACE || b == vclt_pkg::CH_TAB
					|| b == 8'h00)) begin
				if (prop_open) phase = vclt_pkg::PH_BODY;
				else begin
					put(vclt_pkg::KIND_ERROR, 8'h00, vclt_pkg::ERR_ORPHAN);
					phase = vclt_pkg::PH_MUTE;
				end
			end else begin
				if (in_card && prop_open) put(vclt_pkg::KIND_PEND, 8'h00, 2'd0);
				prop_open = 1;
				part = vclt_pkg::FP_NAME;
				kw_alive = 2'b11;
				head_n = 0;
				phase = vclt_pkg::PH_HEAD;
				keyword_byte(b);
			end
		end else if (phase == vclt_pkg::PH_HEAD) begin
			keyword_byte(b);
		end else begin
			release_trail();
			text_byte(b);
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
		foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
	endfunction

	function void check_token(vclt_pkg::res_item_t got);
		vclt_pkg::res_item_t want;
		results_seen++;
		if (pending_tokens.size() == 0) begin
			errors++;
			$display("%0t: unexpected token kind=%0d byte=%h err=%0d last=%0d", $time,
				got.out_kind, got.out_byte, got.error_code, got.last_of_run);
			return;
		end
		want = pending_tokens.pop_front();
		if (got.out_kind !== want.out_kind) begin
			errors++;
			$display("%0t: out_kind expected %0d actual %0d", $time, want.out_kind,
				got.out_kind);
		end
		if (got.out_byte !== want.out_byte) begin
			errors++;
			$display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
				got.out_byte);
		end
		if (got.error_code !== want.error_code) begin
			errors++;
			$display("%0t: error_code expected %0d actual %0d", $time, want.error_code,
				got.error_code);
		end
		if (got.last_of_run !== want.last_of_run) begin
			errors++;
			$display("%0t: last_of_run expected %0d actual %0d", $time,
				want.last_of_run, got.last_of_run);
		end
	endfunction
endclass

module tb_vcard_content_line_tokenizer_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	vclt_pkg::in_item_t item = '0;
	logic full;
	logic empty;
	logic pop = 1'b0;
	vclt_pkg::res_item_t result;

	card_scoreboard sb;
	longint cycles = 0;
	int hold_cycles = 0;
	bit long_hold_req = 0;

	vcard_content_line_tokenizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_token(result);
		if (arst_n && push && !full) sb.note_request(item);
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver: random pops, steady pops in a recurring window, plus one long hold-off when asked.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				pop <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < 150) begin
					@(negedge clk);
					hold_cycles++;
				end
				long_hold_req = 0;
			end else if (cycles % 600 < 150) begin
				pop <= 1'b1;
			end else begin
				pop <= (gap_len() == 0);
			end
		end
	end

	// Returns at the accepting edge with push still high; the next send, if it has a
	// gap, or drain lowers it at the following falling edge.
	task automatic send(logic k, logic [7:0] b, bit burst = 0);
		int g;
		g = burst ? 0 : gap_len();
		@(negedge clk);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
		push <= 1'b1;
		item.kind <= k;
		item.data_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending_tokens.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return vclt_pkg::CH_SEMI;
		if (r < 14) return vclt_pkg::CH_COLON;
		if (r < 20) return vclt_pkg::CH_CR;
		if (r < 23) return vclt_pkg::CH_NUL;
		if (r < 25) return vclt_pkg::CH_VT;
		if (r < 27) return vclt_pkg::CH_FF;
		if (r < 30) return 8'h80 | 8'($urandom_range(0, 127));
		if (r < 60) return 8'($urandom_range(32'h41, 32'h5A));
		return 8'($urandom_range(32'h20, 32'h7E));
	endfunction

	task automatic random_line();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send(1'b0, ($urandom_range(0, 1)) ? vclt_pkg::CH_SPACE : vclt_pkg::CH_TAB);
		end else if (r < 15) begin
			send_text(($urandom_range(0, 1)) ? "end:vcard" : "END:VCARD");
			send(1'b0, vclt_pkg::CH_LF);
			return;
		end else if (r < 17) begin
			send_text("BEGIN:VCARD");
			send(1'b0, vclt_pkg::CH_LF);
			return;
		end
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++) send(1'b0, rand_char());
		if ($urandom_range(0, 3) == 0) send(1'b0, vclt_pkg::CH_CR);
		send(1'b0, vclt_pkg::CH_LF);
	endtask

	initial begin
		sb = new(vclt_pkg::TRAIL_DEPTH_DEF);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: orphan continuation, card open, property with params, folding,
		// extreme bytes, end of input inside a card.
		send(1'b0, vclt_pkg::CH_SPACE);
		send(1'b0, vclt_pkg::CH_LF);
		send_text("begin:vcard");
		send(1'b0, vclt_pkg::CH_LF);
		send_text("N;Ty=X:v");
		send(1'b0, 8'hFF);
		send(1'b0, vclt_pkg::CH_CR);
		send(1'b0, vclt_pkg::CH_LF);
		send(1'b0, vclt_pkg::CH_TAB);
		send(1'b0, 8'h01);
		send(1'b0, vclt_pkg::CH_LF);
		send(1'b0, 8'h00);
		send(1'b1, 8'hFF);
		drain();

		// Trailing-byte overflow, then a card end.
		send_text("BEGIN:VCARD");
		send(1'b0, vclt_pkg::CH_LF);
		send(1'b0, 8'h41);
		repeat (18) send(1'b0, vclt_pkg::CH_VT);
		send(1'b0, 8'h42);
		send(1'b0, vclt_pkg::CH_LF);
		send_text("END:VCARD");
		send(1'b0, vclt_pkg::CH_LF);
		drain();

		// Long receiver hold-off while requests keep arriving.
		long_hold_req = 1;
		send_text("BEGIN:VCARD");
		send(1'b0, vclt_pkg::CH_LF);
		for (int i = 0; i < 30; i++) send(1'b0, rand_char(), 1);
		send(1'b0, vclt_pkg::CH_LF);
		drain();

		// Random cards; the nested begin case halts, so it is kept for the end.
		while (sb.items_noted < 365) begin
			send_text("BEGIN:VCARD");
			send(1'b0, vclt_pkg::CH_LF);
			repeat ($urandom_range(1, 6)) random_line();
			if ($urandom_range(0, 4) == 0) send(1'b1, 8'($urandom_range(0, 255)));
			else begin
				send_text("END:VCARD");
				send(1'b0, vclt_pkg::CH_LF);
			end
			if ($urandom_range(0, 5) == 0) drain();
		end
		send_text("BEGIN:VCARD");
		send(1'b0, vclt_pkg::CH_LF);
		send_text("BEGIN:VCARD");
		send(1'b0, vclt_pkg::CH_LF);
		send_text("X:1");
		send(1'b1, 8'h00);
		drain();
		repeat (50) @(negedge clk);

		$display("Sent %0d requests and checked %0d tokens across cards, folding,",
			sb.items_noted, sb.results_seen);
		$display("trailing bytes, stalls and every error case.");
		if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
